>>> design/sfs_pkg.sv
// Package for the s-expression form splitter: character codes, widths,
// result and queue-push types, and saturating depth helpers. No dependencies.
`default_nettype none

package sfs_pkg;

  localparam int unsigned MaxBufferLen = 65536;
  localparam int unsigned DepthBits    = 16;
  localparam int unsigned PosW         = $clog2(MaxBufferLen);
  localparam int unsigned OffsetW      = PosW + 1;
  localparam int unsigned CountW       = 16;

  localparam logic [7:0] ChParOpen  = 8'h28;
  localparam logic [7:0] ChParClose = 8'h29;
  localparam logic [7:0] ChQuote    = 8'h22;
  localparam logic [7:0] ChSemi     = 8'h3b;
  localparam logic [7:0] ChBslash   = 8'h5c;
  localparam logic [7:0] ChNewline  = 8'h0a;
  localparam logic [7:0] ChSpace    = 8'h20;
  localparam logic [7:0] ChTab      = 8'h09;
  localparam logic [7:0] ChCr       = 8'h0d;

  typedef logic signed [DepthBits-1:0] depth_t;

  localparam depth_t DepthMax = {1'b0, {(DepthBits-1){1'b1}}};
  localparam depth_t DepthMin = {1'b1, {(DepthBits-1){1'b0}}};

  typedef struct packed {
    logic        is_summary;
    logic [15:0] span_start;
    logic [16:0] span_end;
    logic        balanced;
    logic [15:0] form_total;
    logic        last_of_run;
  } sfs_result_t;

  typedef struct packed {
    logic [1:0]  cnt;
    sfs_result_t r0;
    sfs_result_t r1;
  } sfs_push_t;

  function automatic depth_t depth_up(input depth_t d);
    return (d != DepthMax) ? depth_t'(d + depth_t'(1)) : d;
  endfunction

  function automatic depth_t depth_down(input depth_t d);
    return (d != DepthMin) ? depth_t'(d - depth_t'(1)) : d;
  endfunction

endpackage

`default_nettype wire

>>> design/sfs_in_if.sv
// Input channel of the form splitter: one buffer byte per transaction.
// Depends on nothing.
`default_nettype none

interface sfs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_buffer;

  modport source (output valid, output ch, output end_of_buffer, input ready);
  modport sink   (input valid, input ch, input end_of_buffer, output ready);
endinterface

`default_nettype wire

>>> design/sfs_out_if.sv
// Output channel of the form splitter: one span or summary per transaction.
// Depends on nothing.
`default_nettype none

interface sfs_out_if;
  logic        valid;
  logic        ready;
  logic        is_summary;
  logic [15:0] span_start;
  logic [16:0] span_end;
  logic        balanced;
  logic [15:0] form_total;
  logic        last_of_run;

  modport source (output valid, output is_summary, output span_start, output span_end,
                  output balanced, output form_total, output last_of_run, input ready);
  modport sink   (input valid, input is_summary, input span_start, input span_end,
                  input balanced, input form_total, input last_of_run, output ready);
endinterface

`default_nettype wire

>>> design/sfs_core.sv
// Splitter and balance state with the per-byte update and result build.
// Depends on sfs_pkg.
`default_nettype none

module sfs_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_i,
  input  wire logic [7:0]        ch_i,
  input  wire logic              eob_i,
  output sfs_pkg::sfs_push_t     push_o
);
  import sfs_pkg::*;

  logic [OffsetW-1:0] offset_q, offset_d;
  depth_t             split_depth_q, split_depth_d;
  logic               split_str_q, split_str_d;
  logic               split_esc_q, split_esc_d;
  logic               comment_q, comment_d;
  logic               form_open_q, form_open_d;
  logic [PosW-1:0]    open_start_q, open_start_d;
  depth_t             bal_depth_q, bal_depth_d;
  logic               bal_str_q, bal_str_d;
  logic               bal_esc_q, bal_esc_d;
  logic [CountW-1:0]  count_q, count_d;

  logic [PosW-1:0]    pos;
  logic [OffsetW-1:0] pos_next;
  logic               is_space;
  logic               split_emit;
  logic [OffsetW-1:0] split_end;
  logic               open_mid;
  depth_t             depth_dn;
  logic               span_valid;
  logic [CountW-1:0]  count_inc;
  sfs_result_t        span_r, summ_r;

  always_comb begin
    pos      = (offset_q < OffsetW'(MaxBufferLen)) ? offset_q[PosW-1:0]
                                                   : PosW'(MaxBufferLen - 1);
    pos_next = {1'b0, pos} + OffsetW'(1);
    is_space = (ch_i == ChSpace) || ((ch_i >= ChTab) && (ch_i <= ChCr));

    bal_depth_d = bal_depth_q;
    bal_str_d   = bal_str_q;
    bal_esc_d   = bal_esc_q;
    if (bal_esc_q) begin
      bal_esc_d = 1'b0;
    end else if ((ch_i == ChBslash) && bal_str_q) begin
      bal_esc_d = 1'b1;
    end else if (ch_i == ChQuote) begin
      bal_str_d = !bal_str_q;
    end else if (!bal_str_q) begin
      if (ch_i == ChParOpen) begin
        bal_depth_d = depth_up(bal_depth_q);
      end else if (ch_i == ChParClose) begin
        bal_depth_d = depth_down(bal_depth_q);
      end
    end

    split_depth_d = split_depth_q;
    split_str_d   = split_str_q;
    split_esc_d   = split_esc_q;
    comment_d     = comment_q;
    open_mid      = form_open_q;
    open_start_d  = open_start_q;
    split_emit    = 1'b0;
    split_end     = pos_next;
    depth_dn      = depth_down(split_depth_q);
    if (comment_q) begin
      if (ch_i == ChNewline) begin
        comment_d = 1'b0;
      end
    end else if (split_esc_q) begin
      split_esc_d = 1'b0;
    end else if ((ch_i == ChBslash) && split_str_q) begin
      split_esc_d = 1'b1;
    end else if (ch_i == ChQuote) begin
      split_str_d = !split_str_q;
      if (!form_open_q) begin
        open_mid     = 1'b1;
        open_start_d = pos;
      end
    end else if (split_str_q) begin
      open_mid = form_open_q;
    end else if (is_space || (ch_i == ChSemi)) begin
      if ((split_depth_q == '0) && form_open_q) begin
        split_emit = 1'b1;
        split_end  = {1'b0, pos};
      end
      if (ch_i == ChSemi) begin
        comment_d = 1'b1;
      end
    end else begin
      if (!form_open_q) begin
        open_mid     = 1'b1;
        open_start_d = pos;
      end
      if (ch_i == ChParOpen) begin
        split_depth_d = depth_up(split_depth_q);
      end else if (ch_i == ChParClose) begin
        split_depth_d = depth_dn;
        if (depth_dn == '0) begin
          split_emit = 1'b1;
        end
      end
    end

    form_open_d = open_mid && !split_emit;
    span_valid  = split_emit || (eob_i && form_open_d);
    count_inc   = (span_valid && (count_q != '1)) ? count_q + CountW'(1) : count_q;

    span_r = '{is_summary: 1'b0, span_start: open_start_d,
               span_end: split_emit ? split_end : pos_next,
               balanced: 1'b0, form_total: '0, last_of_run: !eob_i};
    summ_r = '{is_summary: 1'b1, span_start: '0, span_end: '0,
               balanced: ((bal_depth_d <= depth_t'(0)) && !bal_str_d),
               form_total: count_inc, last_of_run: 1'b1};

    push_o.cnt = {1'b0, span_valid} + {1'b0, eob_i};
    push_o.r0  = span_valid ? span_r : summ_r;
    push_o.r1  = summ_r;

    offset_d = (offset_q < OffsetW'(MaxBufferLen)) ? offset_q + OffsetW'(1) : offset_q;
    count_d  = count_inc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q      <= '0;
      split_depth_q <= '0;
      split_str_q   <= 1'b0;
      split_esc_q   <= 1'b0;
      comment_q     <= 1'b0;
      form_open_q   <= 1'b0;
      open_start_q  <= '0;
      bal_depth_q   <= '0;
      bal_str_q     <= 1'b0;
      bal_esc_q     <= 1'b0;
      count_q       <= '0;
    end else if (step_i) begin
      if (eob_i) begin
        offset_q      <= '0;
        split_depth_q <= '0;
        split_str_q   <= 1'b0;
        split_esc_q   <= 1'b0;
        comment_q     <= 1'b0;
        form_open_q   <= 1'b0;
        open_start_q  <= '0;
        bal_depth_q   <= '0;
        bal_str_q     <= 1'b0;
        bal_esc_q     <= 1'b0;
        count_q       <= '0;
      end else begin
        offset_q      <= offset_d;
        split_depth_q <= split_depth_d;
        split_str_q   <= split_str_d;
        split_esc_q   <= split_esc_d;
        comment_q     <= comment_d;
        form_open_q   <= form_open_d;
        open_start_q  <= open_start_d;
        bal_depth_q   <= bal_depth_d;
        bal_str_q     <= bal_str_d;
        bal_esc_q     <= bal_esc_d;
        count_q       <= count_d;
      end
    end
  end

endmodule

`default_nettype wire

>>> design/sfs_out_queue.sv
// Four-entry result queue taking up to two results per cycle.
// Depends on sfs_pkg and sfs_out_if.
`default_nettype none

module sfs_out_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  sfs_pkg::sfs_push_t push_data_i,
  output logic               room_o,
  sfs_out_if.source          out_o
);
  import sfs_pkg::*;

  sfs_result_t mem_q [4];
  logic [1:0]  wr_ptr_q, wr_ptr_d;
  logic [1:0]  rd_ptr_q, rd_ptr_d;
  logic [2:0]  count_q, count_d;
  logic [1:0]  push_cnt;
  logic        pop;
  sfs_result_t head;

  always_comb begin
    push_cnt = push_i ? push_data_i.cnt : 2'd0;
    pop      = (count_q != 3'd0) && out_o.ready;
    wr_ptr_d = wr_ptr_q + push_cnt;
    rd_ptr_d = rd_ptr_q + {1'b0, pop};
    count_d  = count_q + {1'b0, push_cnt} - {2'b0, pop};
    room_o   = (count_q <= 3'd2);
    head     = mem_q[rd_ptr_q];

    out_o.valid       = (count_q != 3'd0);
    out_o.is_summary  = head.is_summary;
    out_o.span_start  = head.span_start;
    out_o.span_end    = head.span_end;
    out_o.balanced    = head.balanced;
    out_o.form_total  = head.form_total;
    out_o.last_of_run = head.last_of_run;
  end

  always_ff @(posedge clk_i) begin
    if (push_cnt != 2'd0) begin
      mem_q[wr_ptr_q] <= push_data_i.r0;
    end
    if (push_cnt == 2'd2) begin
      mem_q[wr_ptr_q + 2'd1] <= push_data_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

`default_nettype wire

>>> design/sexpr_form_splitter.sv
// Bytes are registered before their results enter the queue. One byte is taken
// per cycle while the queue has room; an end-of-buffer byte that closes a form
// puts out two results, drained one per cycle from a four-entry queue while
// the sink is ready. Rate is set by the byte register feeding the state update.
// Reset clears splitter, balance and queue control state; no clearing pass.
`default_nettype none

module sexpr_form_splitter (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  sfs_in_if.sink    in_i,
  sfs_out_if.source out_o
);
  import sfs_pkg::*;

  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_ch_q;
  logic       s1_eob_q;
  logic       room;
  logic       advance;
  sfs_push_t  push;

  always_comb begin
    advance    = s1_valid_q && room;
    in_i.ready = !s1_valid_q || advance;
    s1_valid_d = (in_i.valid && in_i.ready) || (s1_valid_q && !advance);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_ch_q  <= in_i.ch;
      s1_eob_q <= in_i.end_of_buffer;
    end
  end

  sfs_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .ch_i   (s1_ch_q),
    .eob_i  (s1_eob_q),
    .push_o (push)
  );

  sfs_out_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (advance),
    .push_data_i (push),
    .room_o      (room),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire
